>>> design/integer_pixel_replication_upscaler_assert.svh
// assertion macros used by the checker
`ifndef INTEGER_PIXEL_REPLICATION_UPSCALER_ASSERT_SVH
`define INTEGER_PIXEL_REPLICATION_UPSCALER_ASSERT_SVH

// same-cycle implication, off during reset
`define IPRU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipru: same-cycle check failed");

// next-cycle implication, off during reset
`define IPRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipru: next-cycle check failed");

// next-cycle implication, also active during reset
`define IPRU_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ipru: reset check failed");

`endif

>>> design/ipru_pkg.sv
package ipru_pkg;

    localparam int SCALE_W = 7;
    localparam int WIDTH_W = 11;
    localparam int COPY_W  = 6;
    localparam int PAD_W   = 2;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;

    typedef logic [PIX_W-1:0] t_pix;

    typedef enum logic {
        CMD_PIXEL   = 1'b0,
        CMD_ADVANCE = 1'b1
    } t_cmd;

    typedef enum logic {
        REG_SCALE     = 1'b0,
        REG_ROW_WIDTH = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic               rejected;
        logic               use_mem;
        logic               row_done;
        logic [PAD_W-1:0]   pad;
        logic [SCALE_W-1:0] scale;
        t_pix               pix;
    } t_job;

    typedef struct packed {
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  red;
        logic             row_end;
        logic [PAD_W-1:0] pad;
        logic             rejected;
        logic             last;
    } t_beat;

endpackage

>>> design/ipru_line_buf.sv
module ipru_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  ipru_pkg::t_pix i_wdata,
    output ipru_pkg::t_pix o_rdata
);
    import ipru_pkg::*;

    t_pix r_mem [DEPTH];
    t_pix r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/ipru_seq.sv
module ipru_seq #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_SCALE = 64,
    parameter int AW        = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  ipru_pkg::t_cmd                 i_cmd,
    input  ipru_pkg::t_pix                 i_pix,
    input  logic [ipru_pkg::SCALE_W-1:0]   i_scale,
    input  logic [ipru_pkg::WIDTH_W-1:0]   i_row_width,
    output ipru_pkg::t_job                 o_job,
    output logic                           o_mem_we,
    output logic                           o_mem_re,
    output logic [AW-1:0]                  o_mem_addr,
    output ipru_pkg::t_pix                 o_mem_wdata
);
    import ipru_pkg::*;

    localparam int WC_W = (AW + 1 > WIDTH_W) ? AW + 1 : WIDTH_W;

    typedef enum logic {
        PH_FILL,
        PH_REPLAY
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [AW-1:0]       r_column, n_column;
    logic [COPY_W-1:0]   r_repeats, n_repeats;

    logic [SCALE_W-1:0]  eff_scale;
    logic [WC_W-1:0]     eff_width;
    logic [WC_W-1:0]     col_next;
    logic [3:0]          pad_prod;
    logic                row_done;
    logic                mismatch;

    always_comb begin
        if (i_scale == '0) begin
            eff_scale = SCALE_W'(1);
        end else if (i_scale > SCALE_W'(MAX_SCALE)) begin
            eff_scale = SCALE_W'(MAX_SCALE);
        end else begin
            eff_scale = i_scale;
        end
        if (i_row_width == '0) begin
            eff_width = WC_W'(1);
        end else if (WC_W'(i_row_width) > WC_W'(MAX_WIDTH)) begin
            eff_width = WC_W'(MAX_WIDTH);
        end else begin
            eff_width = WC_W'(i_row_width);
        end
        col_next = WC_W'(r_column) + WC_W'(1);
        row_done = (col_next >= eff_width);
        pad_prod = eff_width[1:0] * eff_scale[1:0];
        mismatch = (r_phase == PH_FILL) ? (i_cmd != CMD_PIXEL) : (i_cmd != CMD_ADVANCE);
    end

    always_comb begin
        o_job.rejected = mismatch;
        o_job.use_mem  = (r_phase == PH_REPLAY);
        o_job.row_done = row_done;
        o_job.pad      = pad_prod[1:0];
        o_job.scale    = eff_scale;
        o_job.pix      = i_pix;
        o_mem_addr     = r_column;
        o_mem_wdata    = i_pix;
        o_mem_we       = i_accept && !mismatch && (r_phase == PH_FILL);
        o_mem_re       = i_accept && !mismatch && (r_phase == PH_REPLAY);
    end

    always_comb begin
        n_phase   = r_phase;
        n_column  = r_column;
        n_repeats = r_repeats;
        if (i_accept && !mismatch) begin
            if (row_done) begin
                n_column = '0;
                unique case (r_phase)
                    PH_FILL: begin
                        if (eff_scale > SCALE_W'(1)) begin
                            n_repeats = COPY_W'(eff_scale - SCALE_W'(1));
                            n_phase   = PH_REPLAY;
                        end
                    end
                    PH_REPLAY: begin
                        n_repeats = r_repeats - COPY_W'(1);
                        if (n_repeats == '0) begin
                            n_phase = PH_FILL;
                        end
                    end
                    default: n_phase = PH_FILL;
                endcase
            end else begin
                n_column = col_next[AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_FILL;
            r_column  <= '0;
            r_repeats <= '0;
        end else begin
            r_phase   <= n_phase;
            r_column  <= n_column;
            r_repeats <= n_repeats;
        end
    end

endmodule

>>> design/ipru_emit.sv
module ipru_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  ipru_pkg::t_job  i_job,
    input  ipru_pkg::t_pix  i_rdata,
    input  logic            i_ready,
    output logic            o_free,
    output logic            o_valid,
    output ipru_pkg::t_beat o_beat
);
    import ipru_pkg::*;

    t_job              r_job;
    logic              r_job_valid;
    logic [COPY_W-1:0] r_copy;
    logic              r_out_valid;
    t_beat             r_beat;

    t_pix  pix;
    logic  last_copy;
    logic  issue;
    t_beat beat;

    always_comb begin
        pix       = r_job.use_mem ? i_rdata : r_job.pix;
        last_copy = r_job.rejected || (r_copy == COPY_W'(r_job.scale - SCALE_W'(1)));
        issue     = r_job_valid && (!r_out_valid || i_ready);
        o_free    = !r_job_valid || (issue && last_copy);

        beat.blue     = r_job.rejected ? '0 : pix[CH_W-1:0];
        beat.green    = r_job.rejected ? '0 : pix[2*CH_W-1:CH_W];
        beat.red      = r_job.rejected ? '0 : pix[3*CH_W-1:2*CH_W];
        beat.row_end  = !r_job.rejected && last_copy && r_job.row_done;
        beat.pad      = beat.row_end ? r_job.pad : '0;
        beat.rejected = r_job.rejected;
        beat.last     = last_copy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_job_valid <= 1'b1;
                r_job       <= i_job;
                r_copy      <= '0;
            end else if (issue) begin
                if (last_copy) begin
                    r_job_valid <= 1'b0;
                end else begin
                    r_copy <= r_copy + COPY_W'(1);
                end
            end
            if (issue) begin
                r_out_valid <= 1'b1;
                r_beat      <= beat;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_beat  = r_beat;

endmodule

>>> design/integer_pixel_replication_upscaler.sv
// nearest-neighbor integer upscaler for 24-bit pixels
// input channel: i_valid/o_ready beat carries i_command and a pixel
//   command pixel stores the pixel in the line buffer and sends it scale times
//   command advance replays the stored pixel of the current column scale times
//   a command that does not fit the phase gives one beat with o_rejected set
// output channel: o_valid/i_ready, one pixel copy per beat, o_last on the
//   final beat of an item, o_row_end and o_pad_bytes on the last copy of a row
// on accept an item enters the job register; its beats then pass the output register
// each item gives s beats, s = effective scale (1..64), and one beat when it is
//   rejected; the output register sends one beat per cycle while i_ready is high
// the next item is taken as the last beat of the current one enters the output register
// when i_ready is low while o_valid is high the output beat holds and copies stop advancing
// reset clears phase, column, repeat count and both channels; scale and
//   row_width return to 1; line buffer contents are not cleared
// configuration via apb: scale at 0x0, row_width at 0x4; user writes only when idle, not enforced
module integer_pixel_replication_upscaler #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_SCALE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_red,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_red,
    output logic        o_row_end,
    output logic [1:0]  o_pad_bytes,
    output logic        o_rejected,
    output logic        o_last
);
    import ipru_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [SCALE_W-1:0] r_scale;
    logic [WIDTH_W-1:0] r_row_width;

    logic          cfg_wr;
    logic          accept;
    logic          free;
    t_job          job;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    t_pix          mem_wdata;
    t_pix          mem_rdata;
    t_beat         beat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= SCALE_W'(1);
            r_row_width <= WIDTH_W'(1);
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_SCALE:     r_scale     <= pwdata[SCALE_W-1:0];
                REG_ROW_WIDTH: r_row_width <= pwdata[WIDTH_W-1:0];
                default:       r_scale     <= r_scale;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_SCALE:     prdata = 32'(r_scale);
            REG_ROW_WIDTH: prdata = 32'(r_row_width);
            default:       prdata = '0;
        endcase
    end

    assign o_ready = free;
    assign accept  = i_valid && free;

    ipru_seq #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE),
        .AW        (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_cmd       (t_cmd'(i_command)),
        .i_pix       ({i_red, i_green, i_blue}),
        .i_scale     (r_scale),
        .i_row_width (r_row_width),
        .o_job       (job),
        .o_mem_we    (mem_we),
        .o_mem_re    (mem_re),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata)
    );

    ipru_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    ipru_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_job   (job),
        .i_rdata (mem_rdata),
        .i_ready (i_ready),
        .o_free  (free),
        .o_valid (o_valid),
        .o_beat  (beat)
    );

    assign o_out_blue  = beat.blue;
    assign o_out_green = beat.green;
    assign o_out_red   = beat.red;
    assign o_row_end   = beat.row_end;
    assign o_pad_bytes = beat.pad;
    assign o_rejected  = beat.rejected;
    assign o_last      = beat.last;

endmodule

>>> design/ipru_checker.sv
`include "integer_pixel_replication_upscaler_assert.svh"

module ipru_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_blue,
    input logic [7:0] o_out_green,
    input logic [7:0] o_out_red,
    input logic       o_row_end,
    input logic [1:0] o_pad_bytes,
    input logic       o_rejected,
    input logic       o_last
);

    `IPRU_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_valid && o_ready)

    `IPRU_ASSERT_IMP(a_reject_beat, i_clk, i_rst_n, o_valid && o_rejected, o_last && !o_row_end && o_pad_bytes == 2'd0 && o_out_blue == 8'd0 && o_out_green == 8'd0 && o_out_red == 8'd0)

    `IPRU_ASSERT_IMP(a_pad_with_row_end, i_clk, i_rst_n, o_valid && !o_row_end, o_pad_bytes == 2'd0)

    `IPRU_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out_blue) && $stable(o_out_green) && $stable(o_out_red) && $stable(o_last))

endmodule

bind integer_pixel_replication_upscaler ipru_checker u_ipru_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_out_blue  (o_out_blue),
    .o_out_green (o_out_green),
    .o_out_red   (o_out_red),
    .o_row_end   (o_row_end),
    .o_pad_bytes (o_pad_bytes),
    .o_rejected  (o_rejected),
    .o_last      (o_last)
);
